### rtl/mtde_pkg.sv
// ----------------------------------------------------------------------------
// Timer deadline engine package
// Shared item types, action and unit codes, conversion constants and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtde_pkg;

  localparam int unsigned DEF_NUM_SLOTS = 16;
  localparam int unsigned MAX_RESULTS   = 16;

  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_ENABLE  = 3'd1;
  localparam logic [2:0] ACT_DISABLE = 3'd2;
  localparam logic [2:0] ACT_DELETE  = 3'd3;
  localparam logic [2:0] ACT_CHECK   = 3'd4;
  localparam logic [2:0] ACT_DRAIN   = 3'd5;

  localparam logic [1:0] UNIT_MS = 2'd0;
  localparam logic [1:0] UNIT_US = 2'd1;
  localparam logic [1:0] UNIT_NS = 2'd2;
  localparam logic [1:0] UNIT_S  = 2'd3;

  localparam logic signed [63:0] I64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] NS_PER_S  = 64'sd1000000000;
  localparam logic signed [63:0] NS_PER_MS = 64'sd1000000;
  localparam logic signed [63:0] NS_PER_US = 64'sd1000;

  localparam logic signed [63:0] HI_S  = I64_MAX / NS_PER_S;
  localparam logic signed [63:0] LO_S  = I64_MIN / NS_PER_S;
  localparam logic signed [63:0] HI_MS = I64_MAX / NS_PER_MS;
  localparam logic signed [63:0] LO_MS = I64_MIN / NS_PER_MS;
  localparam logic signed [63:0] HI_US = I64_MAX / NS_PER_US;
  localparam logic signed [63:0] LO_US = I64_MIN / NS_PER_US;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         slot;
    logic signed [63:0] amount;
    logic [1:0]         unit;
    logic               single_shot;
    logic               absolute_mode;
    logic [62:0]        now_ns;
    logic [62:0]        wall_now_ns;
    logic [4:0]         max_events;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [3:0]         event_slot;
    logic [31:0]        fire_cnt;
    logic               has_event;
    logic               last_of_run;
    logic signed [63:0] min_wait_ns;
  } out_t;

  typedef struct packed {
    logic latch;
    logic mul_lo;
    logic mul_hi;
    logic conv;
    logic delta;
    logic create_wr;
    logic reject;
    logic en_wr;
    logic dis_wr;
    logic del_wr;
    logic rd_slot;
    logic idx_clr;
    logic idx_inc;
    logic ck_fire1;
    logic div_start;
    logic ck_upd;
    logic mw_clr;
    logic mw_acc;
    logic mw_fin;
    logic dr_clr;
    logic dr_take;
    logic out_single;
    logic out_fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       in_range;
    logic       neg_rel;
    logic       slot_exists;
    logic       idx_last;
    logic       due_once;
    logic       due_per;
    logic       div_done;
    logic       cand;
    logic       dr_stop;
    logic       pend_valid;
    logic       out_free;
  } sts_t;

  function automatic logic [29:0] unit_factor(input logic [1:0] u);
    logic [29:0] f;
    case (u)
      UNIT_MS: f = 30'(NS_PER_MS);
      UNIT_US: f = 30'(NS_PER_US);
      UNIT_NS: f = 30'd1;
      default: f = 30'(NS_PER_S);
    endcase
    return f;
  endfunction

  function automatic logic signed [63:0] lim_hi(input logic [1:0] u);
    logic signed [63:0] l;
    case (u)
      UNIT_MS: l = HI_MS;
      UNIT_US: l = HI_US;
      UNIT_NS: l = I64_MAX;
      default: l = HI_S;
    endcase
    return l;
  endfunction

  function automatic logic signed [63:0] lim_lo(input logic [1:0] u);
    logic signed [63:0] l;
    case (u)
      UNIT_MS: l = LO_MS;
      UNIT_US: l = LO_US;
      UNIT_NS: l = I64_MIN;
      default: l = LO_S;
    endcase
    return l;
  endfunction

endpackage

### rtl/mtde_div.sv
// ----------------------------------------------------------------------------
// Timer deadline engine divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtde_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [63:0] rem_o
);
  logic [63:0] quot_q, rem_q, dsr_q, rem_sh;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, fits;

  assign rem_sh = {rem_q[62:0], quot_q[63]};
  assign fits   = rem_sh >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[62:0], fits};
      rem_q  <= fits ? (rem_sh - dsr_q) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

### rtl/mtde_ctrl.sv
// ----------------------------------------------------------------------------
// Timer deadline engine controller
// Sequences commands, slot scans, the divider and result delivery.
// ----------------------------------------------------------------------------
module mtde_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mtde_pkg::sts_t  sts_i,
  output mtde_pkg::cmd_t  cmd_o
);
  import mtde_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MUL_HI, S_CONV, S_DELTA, S_CR_WR, S_EN_RD, S_EN_WR,
    S_CK_RD, S_CK_EVAL, S_CK_DIV, S_MW_RD, S_MW_ACC, S_MW_FIN, S_OUT1,
    S_DR_RD, S_DR_EVAL, S_DR_FIN
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        cmd.idx_clr = 1'b1;
        cmd.mw_clr  = 1'b1;
        state_d     = S_MW_RD;
        if (sts_i.action == ACT_CREATE && sts_i.in_range) begin
          if (sts_i.neg_rel) begin
            cmd.reject = 1'b1;
          end else begin
            cmd.mul_lo = 1'b1;
            state_d    = S_MUL_HI;
          end
        end else if (sts_i.action == ACT_ENABLE && sts_i.in_range) begin
          if (sts_i.slot_exists) begin
            state_d = S_EN_RD;
          end
        end else if (sts_i.action == ACT_DISABLE && sts_i.in_range) begin
          cmd.dis_wr = 1'b1;
        end else if (sts_i.action == ACT_DELETE && sts_i.in_range) begin
          cmd.del_wr = 1'b1;
        end else if (sts_i.action == ACT_CHECK || sts_i.action == ACT_DRAIN) begin
          state_d = S_CK_RD;
        end
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_d    = S_CONV;
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        state_d  = S_DELTA;
      end
      S_DELTA: begin
        cmd.delta = 1'b1;
        state_d   = S_CR_WR;
      end
      S_CR_WR: begin
        cmd.create_wr = 1'b1;
        cmd.idx_clr   = 1'b1;
        cmd.mw_clr    = 1'b1;
        state_d       = S_MW_RD;
      end
      S_EN_RD: begin
        cmd.rd_slot = 1'b1;
        state_d     = S_EN_WR;
      end
      S_EN_WR: begin
        cmd.en_wr   = 1'b1;
        cmd.idx_clr = 1'b1;
        cmd.mw_clr  = 1'b1;
        state_d     = S_MW_RD;
      end
      S_CK_RD: begin
        state_d = S_CK_EVAL;
      end
      S_CK_EVAL, S_CK_DIV: begin
        if (state_q == S_CK_EVAL && sts_i.due_per) begin
          cmd.div_start = 1'b1;
          state_d       = S_CK_DIV;
        end else if (state_q == S_CK_EVAL || sts_i.div_done) begin
          cmd.ck_fire1 = (state_q == S_CK_EVAL) && sts_i.due_once;
          cmd.ck_upd   = (state_q == S_CK_DIV);
          if (sts_i.idx_last) begin
            cmd.idx_clr = 1'b1;
            cmd.mw_clr  = 1'b1;
            state_d     = S_MW_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_d     = S_CK_RD;
          end
        end
      end
      S_MW_RD: begin
        state_d = S_MW_ACC;
      end
      S_MW_ACC: begin
        cmd.mw_acc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_MW_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_MW_RD;
        end
      end
      S_MW_FIN: begin
        cmd.mw_fin = 1'b1;
        if (sts_i.action == ACT_DRAIN) begin
          cmd.idx_clr = 1'b1;
          cmd.dr_clr  = 1'b1;
          state_d     = S_DR_RD;
        end else begin
          state_d = S_OUT1;
        end
      end
      S_OUT1: begin
        if (sts_i.out_free) begin
          cmd.out_single = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DR_RD: begin
        state_d = sts_i.dr_stop ? S_DR_FIN : S_DR_EVAL;
      end
      S_DR_EVAL: begin
        if (!(sts_i.cand && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd.dr_take = sts_i.cand;
          if (sts_i.idx_last) begin
            state_d = S_DR_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_d     = S_DR_RD;
          end
        end
      end
      S_DR_FIN: begin
        if (sts_i.out_free) begin
          cmd.out_fin = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### rtl/mtde_datapath.sv
// ----------------------------------------------------------------------------
// Timer deadline engine datapath
// Slot flags and memories, unit conversion, deadline updates, minimum wait
// tracking, drain lookahead and the result register.
// ----------------------------------------------------------------------------
module mtde_datapath #(
  parameter int unsigned NUM_SLOTS = mtde_pkg::DEF_NUM_SLOTS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtde_pkg::in_t   in_data_i,
  input  mtde_pkg::cmd_t  cmd_i,
  output mtde_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mtde_pkg::out_t  out_data_o
);
  import mtde_pkg::*;

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

  in_t                  it_q;
  logic [SW-1:0]        idx_q, slot_idx, ra, wa;
  logic [NUM_SLOTS-1:0] exists_q, enabled_q, armed_q, once_q, abs_q, cnz_q;

  logic [63:0] dl_mem [NUM_SLOTS];
  logic [63:0] pd_mem [NUM_SLOTS];
  logic [31:0] cnt_mem [NUM_SLOTS];
  logic [63:0] dl_rd_q, pd_rd_q, dl_wd, pd_wd;
  logic [31:0] cnt_rd_q, cnt_wd;
  logic        dl_we, pd_we, cnt_we;

  logic [29:0]        factor;
  logic [31:0]        mul_a;
  logic [61:0]        prod, p_lo_q;
  logic [31:0]        p_hi_q;
  logic signed [63:0] conv_raw, conv_q;
  logic [63:0]        ns_q, ns_d, now64, wall64, en_d;

  logic        div_done;
  logic [63:0] div_quot, div_rem;
  logic        due, plain;
  logic [31:0] eff_cnt;
  logic [64:0] add_k, sum;

  logic               any_q, status_q;
  logic [63:0]        best_q, diff;
  logic signed [63:0] w_q, w_d;

  logic [4:0]  n_q, max_ev;
  logic        pend_valid_q;
  logic [3:0]  pend_slot_q;
  logic [31:0] pend_cnt_q;

  logic out_valid_q, out_free, out_ld;
  out_t out_q, out_d;

  assign slot_idx = SW'(it_q.slot);
  assign now64    = {1'b0, it_q.now_ns};
  assign wall64   = {1'b0, it_q.wall_now_ns};
  assign ra       = cmd_i.rd_slot ? slot_idx : idx_q;
  assign wa       = (cmd_i.create_wr || cmd_i.en_wr) ? slot_idx : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      it_q <= in_data_i;
    end
  end

  // Unit conversion: two 32-bit partial products, then saturation.
  assign factor   = unit_factor(it_q.unit);
  assign mul_a    = cmd_i.mul_hi ? it_q.amount[63:32] : it_q.amount[31:0];
  assign prod     = 62'(mul_a * factor);
  assign conv_raw = $signed({p_hi_q, 32'd0} + {2'd0, p_lo_q});

  always_comb begin
    if (it_q.absolute_mode) begin
      if (conv_q > 64'sd0 && $unsigned(conv_q) > wall64) begin
        ns_d = $unsigned(conv_q) - wall64;
      end else begin
        ns_d = '0;
      end
    end else if (conv_q < 64'sd1) begin
      ns_d = 64'd1;
    end else begin
      ns_d = $unsigned(conv_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      p_lo_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      p_hi_q <= prod[31:0];
    end
    if (cmd_i.conv) begin
      if ($signed(it_q.amount) > lim_hi(it_q.unit)) begin
        conv_q <= I64_MAX;
      end else if ($signed(it_q.amount) < lim_lo(it_q.unit)) begin
        conv_q <= I64_MIN;
      end else begin
        conv_q <= conv_raw;
      end
    end
    if (cmd_i.delta) begin
      ns_q <= ns_d;
    end
  end

  mtde_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (now64 - dl_rd_q),
    .divisor_i  (pd_rd_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign due     = armed_q[idx_q] && (now64 >= dl_rd_q);
  assign plain   = once_q[idx_q] || abs_q[idx_q] || (pd_rd_q == 64'd0);
  assign eff_cnt = cnz_q[idx_q] ? cnt_rd_q : 32'd0;
  assign add_k   = cmd_i.ck_upd ? ({1'b0, div_quot} + 65'd1) : 65'd1;
  assign sum     = {33'd0, eff_cnt} + add_k;
  assign en_d    = abs_q[slot_idx] ? 64'd0 : ((pd_rd_q != 64'd0) ? pd_rd_q : 64'd1);

  always_comb begin
    dl_we  = cmd_i.create_wr || cmd_i.en_wr || cmd_i.ck_upd;
    pd_we  = cmd_i.create_wr;
    cnt_we = cmd_i.ck_fire1 || cmd_i.ck_upd;
    if (cmd_i.create_wr) begin
      dl_wd = now64 + ns_q;
    end else if (cmd_i.en_wr) begin
      dl_wd = now64 + en_d;
    end else begin
      dl_wd = now64 - div_rem + pd_rd_q;
    end
    pd_wd  = (it_q.absolute_mode || it_q.single_shot) ? 64'd0 : ns_q;
    cnt_wd = (sum > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[wa] <= dl_wd;
    end
    dl_rd_q <= dl_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (pd_we) begin
      pd_mem[wa] <= pd_wd;
    end
    pd_rd_q <= pd_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q  <= '0;
      enabled_q <= '0;
      armed_q   <= '0;
      once_q    <= '0;
      abs_q     <= '0;
      cnz_q     <= '0;
    end else begin
      if (cmd_i.create_wr) begin
        exists_q[slot_idx]  <= 1'b1;
        enabled_q[slot_idx] <= 1'b1;
        armed_q[slot_idx]   <= 1'b1;
        once_q[slot_idx]    <= it_q.single_shot;
        abs_q[slot_idx]     <= it_q.absolute_mode;
        cnz_q[slot_idx]     <= 1'b0;
      end
      if (cmd_i.reject || cmd_i.del_wr) begin
        exists_q[slot_idx]  <= 1'b0;
        enabled_q[slot_idx] <= 1'b0;
        armed_q[slot_idx]   <= 1'b0;
        once_q[slot_idx]    <= 1'b0;
        abs_q[slot_idx]     <= 1'b0;
        cnz_q[slot_idx]     <= 1'b0;
      end
      if (cmd_i.en_wr) begin
        enabled_q[slot_idx] <= 1'b1;
        armed_q[slot_idx]   <= 1'b1;
        cnz_q[slot_idx]     <= 1'b0;
      end
      if (cmd_i.dis_wr && exists_q[slot_idx]) begin
        enabled_q[slot_idx] <= 1'b0;
        armed_q[slot_idx]   <= 1'b0;
      end
      if (cmd_i.ck_fire1) begin
        armed_q[idx_q] <= 1'b0;
        cnz_q[idx_q]   <= 1'b1;
      end
      if (cmd_i.ck_upd) begin
        cnz_q[idx_q] <= 1'b1;
      end
      if (cmd_i.dr_take) begin
        cnz_q[idx_q] <= 1'b0;
      end
    end
  end

  assign diff = best_q - now64;

  always_comb begin
    if (!any_q) begin
      w_d = -64'sd1;
    end else if (best_q <= now64) begin
      w_d = 64'sd0;
    end else if (diff > $unsigned(I64_MAX)) begin
      w_d = I64_MAX;
    end else begin
      w_d = $signed(diff);
    end
  end

  assign max_ev = (it_q.max_events > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : it_q.max_events;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      any_q        <= 1'b0;
      status_q     <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.mw_clr) begin
        any_q <= 1'b0;
      end else if (cmd_i.mw_acc && armed_q[idx_q] && (!any_q || dl_rd_q < best_q)) begin
        any_q <= 1'b1;
      end
      if (cmd_i.latch) begin
        status_q <= 1'b0;
      end else if (cmd_i.reject) begin
        status_q <= 1'b1;
      end
      if (cmd_i.dr_clr) begin
        n_q          <= '0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.dr_take) begin
        n_q          <= n_q + 5'd1;
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mw_acc && armed_q[idx_q] && (!any_q || dl_rd_q < best_q)) begin
      best_q <= dl_rd_q;
    end
    if (cmd_i.mw_fin) begin
      w_q <= w_d;
    end
    if (cmd_i.dr_take) begin
      pend_slot_q <= 4'(idx_q);
      pend_cnt_q  <= cnt_rd_q;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_ld   = cmd_i.out_single || cmd_i.out_fin || (cmd_i.dr_take && pend_valid_q);

  always_comb begin
    out_d             = '0;
    out_d.status      = status_q;
    out_d.min_wait_ns = w_q;
    out_d.last_of_run = !cmd_i.dr_take;
    if ((cmd_i.dr_take || cmd_i.out_fin) && pend_valid_q) begin
      out_d.event_slot = pend_slot_q;
      out_d.fire_cnt   = pend_cnt_q;
      out_d.has_event  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o             = '0;
    sts_o.action      = it_q.action;
    sts_o.in_range    = {5'd0, it_q.slot} < 9'(NUM_SLOTS);
    sts_o.neg_rel     = !it_q.absolute_mode && it_q.amount[63];
    sts_o.slot_exists = exists_q[slot_idx];
    sts_o.idx_last    = (idx_q == LAST_IDX);
    sts_o.due_once    = due && plain;
    sts_o.due_per     = due && !plain;
    sts_o.div_done    = div_done;
    sts_o.cand        = exists_q[idx_q] && enabled_q[idx_q] && cnz_q[idx_q];
    sts_o.dr_stop     = (n_q == max_ev);
    sts_o.pend_valid  = pend_valid_q;
    sts_o.out_free    = out_free;
  end
endmodule

### rtl/multi_timer_deadline_engine.sv
// ----------------------------------------------------------------------------
// Multi timer deadline engine
// Bank of periodic and single-shot timer slots with check, drain and a
// minimum-wait report on every result.
// ----------------------------------------------------------------------------
// One item is processed at a time. Slot commands are followed by a
// minimum-wait scan over every slot. Check and drain first add a scan of
// the slots, and every due periodic slot waits on the bit-serial 64-bit
// divider that counts missed intervals. Drain then scans the slots again
// and delivers results through a one-deep output register, waiting
// whenever that register is still held by stall.
// The next item is taken once the last result of an item is loaded.
module multi_timer_deadline_engine #(
  parameter int unsigned NUM_SLOTS = mtde_pkg::DEF_NUM_SLOTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtde_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtde_pkg::out_t out_data_o
);
  import mtde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mtde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtde_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline engine testbench
// Drives directed and random timer actions, predicts every result with a
// behavioral slot bank and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import mtde_pkg::*;

  localparam int NSLOT = 16;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  logic [63:0] tm_deadline [NSLOT];
  logic [63:0] tm_period [NSLOT];
  logic tm_once [NSLOT];
  logic tm_abs [NSLOT];
  logic tm_armed [NSLOT];
  logic tm_enabled [NSLOT];
  logic tm_exists [NSLOT];
  logic [31:0] tm_count [NSLOT];

  out_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_rx = 1'b0;
  logic [62:0] mono_ns = 63'd1000;

  multi_timer_deadline_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic signed [63:0] scale_to_ns(logic signed [63:0] a, logic [1:0] u);
    logic signed [63:0] m;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    case (u)
      UNIT_MS: m = 64'sd1000000;
      UNIT_US: m = 64'sd1000;
      UNIT_NS: return a;
      default: m = 64'sd1000000000;
    endcase
    hi = 64'sh7FFF_FFFF_FFFF_FFFF / m;
    lo = 64'sh8000_0000_0000_0000 / m;
    if (a > hi) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < lo) return 64'sh8000_0000_0000_0000;
    return a * m;
  endfunction

  function automatic void bump_count(int s, logic [63:0] k);
    logic [64:0] c;
    c = {33'd0, tm_count[s]} + {1'b0, k};
    if (k > 64'hFFFF_FFFF || c > 65'hFFFF_FFFF) tm_count[s] = 32'hFFFF_FFFF;
    else tm_count[s] = c[31:0];
  endfunction

  function automatic void clear_timer(int s);
    tm_deadline[s] = '0; tm_period[s] = '0; tm_once[s] = 0; tm_abs[s] = 0;
    tm_armed[s] = 0; tm_enabled[s] = 0; tm_exists[s] = 0; tm_count[s] = '0;
  endfunction

  function automatic void fire_due(logic [63:0] now);
    logic [63:0] k;
    for (int s = 0; s < NSLOT; s++) begin
      if (!tm_armed[s] || now < tm_deadline[s]) continue;
      if (tm_once[s] || tm_abs[s] || tm_period[s] == 0) begin
        bump_count(s, 64'd1);
        tm_armed[s] = 0;
      end else begin
        k = (now - tm_deadline[s]) / tm_period[s] + 1;
        bump_count(s, k);
        tm_deadline[s] = tm_deadline[s] + k * tm_period[s];
      end
    end
  endfunction

  function automatic logic [63:0] earliest_wait(logic [63:0] now);
    bit any;
    logic [63:0] best;
    any = 0;
    best = '0;
    for (int s = 0; s < NSLOT; s++) begin
      if (tm_armed[s] && (!any || tm_deadline[s] < best)) begin
        best = tm_deadline[s];
        any = 1;
      end
    end
    if (!any) return '1;
    if (best <= now) return '0;
    best = best - now;
    return best > 64'h7FFF_FFFF_FFFF_FFFF ? 64'h7FFF_FFFF_FFFF_FFFF : best;
  endfunction

  function automatic void predict_timers(in_t it);
    out_t r [$];
    out_t o;
    logic [63:0] now;
    logic [63:0] wall;
    logic signed [63:0] a;
    logic [63:0] d;
    logic st;
    int lim;
    now = {1'b0, it.now_ns};
    wall = {1'b0, it.wall_now_ns};
    st = 0;
    lim = it.max_events > 16 ? 16 : it.max_events;
    case (it.action)
      ACT_CREATE: begin
        clear_timer(it.slot);
        if (it.absolute_mode) begin
          a = scale_to_ns(it.amount, it.unit);
          d = (a > 0 && $unsigned(a) > wall) ? $unsigned(a) - wall : 64'd0;
          tm_deadline[it.slot] = now + d;
          tm_abs[it.slot] = 1;
          tm_once[it.slot] = it.single_shot;
          tm_exists[it.slot] = 1; tm_armed[it.slot] = 1; tm_enabled[it.slot] = 1;
        end else if (it.amount < 0) begin
          st = 1;
        end else begin
          a = scale_to_ns(it.amount, it.unit);
          if (a < 1) a = 1;
          tm_once[it.slot] = it.single_shot;
          tm_period[it.slot] = it.single_shot ? 64'd0 : a;
          tm_deadline[it.slot] = now + a;
          tm_exists[it.slot] = 1; tm_armed[it.slot] = 1; tm_enabled[it.slot] = 1;
        end
      end
      ACT_ENABLE: if (tm_exists[it.slot]) begin
        d = tm_abs[it.slot] ? 64'd0 : (tm_period[it.slot] > 0 ? tm_period[it.slot] : 64'd1);
        tm_deadline[it.slot] = now + d;
        tm_count[it.slot] = '0;
        tm_armed[it.slot] = 1; tm_enabled[it.slot] = 1;
      end
      ACT_DISABLE: if (tm_exists[it.slot]) begin
        tm_armed[it.slot] = 0; tm_enabled[it.slot] = 0;
      end
      ACT_DELETE: clear_timer(it.slot);
      ACT_CHECK: fire_due(now);
      ACT_DRAIN: begin
        fire_due(now);
        for (int s = 0; s < NSLOT && r.size() < lim; s++) begin
          if (tm_exists[s] && tm_enabled[s] && tm_count[s] != 0) begin
            o = '0;
            o.event_slot = 4'(s);
            o.fire_cnt = tm_count[s];
            o.has_event = 1;
            r.push_back(o);
            tm_count[s] = '0;
          end
        end
      end
      default: ;
    endcase
    if (r.size() == 0) r.push_back(out_t'('0));
    d = earliest_wait(now);
    foreach (r[k]) begin
      r[k].status = st;
      r[k].last_of_run = (k == r.size() - 1);
      r[k].min_wait_ns = d;
      expected_q.push_back(r[k]);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && (in_valid_i && !in_stall_o || out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.min_wait_ns, 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.status !== e.status) report_mismatch("status", out_data_o.status, e.status);
        if (out_data_o.event_slot !== e.event_slot)
          report_mismatch("event_slot", out_data_o.event_slot, e.event_slot);
        if (out_data_o.fire_cnt !== e.fire_cnt)
          report_mismatch("fire_cnt", out_data_o.fire_cnt, e.fire_cnt);
        if (out_data_o.has_event !== e.has_event)
          report_mismatch("has_event", out_data_o.has_event, e.has_event);
        if (out_data_o.last_of_run !== e.last_of_run)
          report_mismatch("last_of_run", out_data_o.last_of_run, e.last_of_run);
        if (out_data_o.min_wait_ns !== e.min_wait_ns)
          report_mismatch("min_wait_ns", out_data_o.min_wait_ns, e.min_wait_ns);
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_rx || (!calm && $urandom_range(99) < 36);
  end

  task automatic drop_input();
    logic [223:0] junk;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    in_valid_i <= 1'b0;
    in_data_i <= junk[$bits(in_t)-1:0];
  endtask

  // The item stays offered after acceptance until the next call or drop_input.
  task automatic send_item(in_t it);
    while (!calm && $urandom_range(99) < 36) begin
      drop_input();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    predict_timers(it);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic in_t make_item(logic [2:0] act, logic [3:0] s, logic signed [63:0] amt,
                                    logic [1:0] u, logic once, logic absm);
    in_t it;
    it.action = act; it.slot = s; it.amount = amt; it.unit = u;
    it.single_shot = once; it.absolute_mode = absm;
    it.now_ns = mono_ns;
    it.wall_now_ns = 63'({$urandom, $urandom} >> 1);
    it.max_events = 5'($urandom_range(1, 16));
    return it;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_commands();
    in_t it;
    send_item(make_item(ACT_CREATE, 0, 64'sd5, UNIT_MS, 0, 0));
    send_item(make_item(ACT_CREATE, 1, 64'sd3, UNIT_US, 1, 0));
    send_item(make_item(ACT_CREATE, 2, 64'sd0, UNIT_NS, 0, 0));
    send_item(make_item(ACT_CREATE, 3, 64'sd2, UNIT_S, 0, 0));
    send_item(make_item(ACT_CREATE, 4, -64'sd1, UNIT_NS, 0, 0));
    send_item(make_item(ACT_CREATE, 5, I64_MAX, UNIT_S, 0, 0));
    send_item(make_item(ACT_CREATE, 6, I64_MIN, UNIT_MS, 0, 1));
    send_item(make_item(ACT_CREATE, 15, I64_MAX, UNIT_NS, 1, 1));
    it = make_item(ACT_CREATE, 7, 64'sd1, UNIT_S, 0, 1);
    it.wall_now_ns = 63'd10;
    send_item(it);
    send_item(make_item(ACT_DISABLE, 3, 0, 0, 0, 0));
    send_item(make_item(ACT_DISABLE, 9, 0, 0, 0, 0));
    send_item(make_item(ACT_ENABLE, 9, 0, 0, 0, 0));
    mono_ns = mono_ns + 63'd20_000_000;
    send_item(make_item(ACT_CHECK, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_ENABLE, 6, 0, 0, 0, 0));
    send_item(make_item(ACT_ENABLE, 3, 0, 0, 0, 0));
    it = make_item(ACT_DRAIN, 0, 0, 0, 0, 0);
    it.max_events = 5'd0;
    send_item(it);
    it.max_events = 5'd31;
    send_item(it);
    send_item(make_item(ACT_DELETE, 5, 0, 0, 0, 0));
    send_item(make_item(ACT_SPARE_A, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_SPARE_B, 0, 0, 0, 0, 0));
    mono_ns = 63'h7FFF_FFFF_FFFF_FFF0;
    send_item(make_item(ACT_DRAIN, 0, 0, 0, 0, 0));
    drop_input();
    wait_drained();
  endtask

  task automatic test_random(int n);
    in_t it;
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      case ($urandom_range(9))
        0, 1, 2: act = ACT_CREATE;
        3: act = ACT_ENABLE;
        4: act = ACT_DISABLE;
        5: act = ACT_DELETE;
        6: act = ACT_CHECK;
        7, 8: act = ACT_DRAIN;
        default: act = 3'($urandom_range(7));
      endcase
      mono_ns = mono_ns + $urandom_range(0, 3_000_000);
      if ($urandom_range(19) == 0) mono_ns = 63'({$urandom, $urandom});
      it = make_item(act, 4'($urandom_range(15)), 64'($urandom_range(0, 2000)),
                     2'($urandom_range(3)), 1'($urandom_range(1)), $urandom_range(5) == 0);
      if ($urandom_range(9) == 0) it.amount = {$urandom, $urandom};
      if ($urandom_range(3) == 0) it.unit = UNIT_NS;
      if (it.absolute_mode) it.amount = {1'b0, it.wall_now_ns} + $urandom_range(0, 1 << 20);
      if ($urandom_range(9) == 0) it.max_events = 5'($urandom);
      if ($urandom_range(9) == 0) it.wall_now_ns = 63'({$urandom, $urandom});
      send_item(it);
    end
    calm = 1'b0;
    drop_input();
    wait_drained();
  endtask

  task automatic test_backpressure();
    in_t it;
    for (int s = 0; s < NSLOT; s++)
      send_item(make_item(ACT_CREATE, 4'(s), 64'sd1, UNIT_NS, 0, 0));
    drop_input();
    wait_drained();
    fork
      begin
        hold_rx = 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        for (int k = 0; k < 6; k++) begin
          mono_ns = mono_ns + 63'd40;
          send_item(make_item(ACT_DRAIN, 0, 0, 0, 0, 0));
        end
        drop_input();
      end
    join
    wait_drained();
  endtask

  initial begin
    for (int s = 0; s < NSLOT; s++) clear_timer(s);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_commands();
    test_backpressure();
    test_random(66);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/mtde_pkg.sv
rtl/mtde_div.sv
rtl/mtde_ctrl.sv
rtl/mtde_datapath.sv
rtl/multi_timer_deadline_engine.sv
dv/tb_top.sv
